// ----- src/accel_window_feature_extractor_core_assert.svh -----
// assertion macros used by the block's datapath rtl
`ifndef ACCEL_WINDOW_FEATURE_EXTRACTOR_CORE_ASSERT_SVH
`define ACCEL_WINDOW_FEATURE_EXTRACTOR_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define AWFE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("awfe check failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define AWFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("awfe check failed: next-cycle implication");

`endif

// ----- src/awfe_pkg.sv -----
`default_nettype none
package awfe_pkg;

    localparam int AWFE_DEPTH_DEFAULT = 32;
    localparam int FILL_W             = 7;
    localparam int SAMPLE_W           = 16;
    localparam int SPAN_W             = 16;
    localparam int ENERGY_W           = 24;
    localparam int MEAN_W             = 18;
    localparam int AGE_W              = 6;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_FEAT  = 2'd1;
    localparam logic [1:0] OP_DUMP  = 2'd2;
    localparam logic [1:0] OP_RAW   = 2'd3;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    localparam logic signed [8:0] NORM_MAX = 9'sd127;
    localparam logic signed [8:0] NORM_MIN = -9'sd128;

    typedef struct packed {
        logic [1:0]                 opcode;
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic [AGE_W-1:0]           age_index;
    } in_item_t;

    typedef struct packed {
        logic                       status;
        logic [FILL_W-1:0]          fill_count;
        logic signed [SAMPLE_W-1:0] sample_x;
        logic signed [SAMPLE_W-1:0] sample_y;
        logic signed [SAMPLE_W-1:0] sample_z;
        logic [SPAN_W-1:0]          span_x;
        logic [SPAN_W-1:0]          span_y;
        logic [SPAN_W-1:0]          span_z;
        logic [SPAN_W-1:0]          largest_span;
        logic [ENERGY_W-1:0]        delta_energy;
        logic [MEAN_W-1:0]          mean_delta;
        logic                       last;
    } out_item_t;

    typedef enum logic [2:0] {
        RES_PUSH,
        RES_ERR,
        RES_FEAT,
        RES_RAW,
        RES_DUMP
    } res_kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FEAT_WALK,
        S_DIV_START,
        S_DIV_WAIT,
        S_DUMP_RD,
        S_DUMP_EMIT,
        S_EMIT_PUSH,
        S_EMIT_ERR,
        S_EMIT_RAW,
        S_EMIT_FEAT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic      take;
        logic      push;
        logic      walk_issue;
        logic      raw_issue;
        logic      div_start;
        logic      out_load;
        res_kind_t out_kind;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       in_fire;
        logic [1:0] op;
        logic       empty;
        logic       full;
        logic       age_bad;
        logic       walk_done;
        logic       rd_pend;
        logic       out_free;
        logic       div_done;
    } stat_t;

endpackage
`default_nettype wire

// ----- src/awfe_in_if.sv -----
`default_nettype none
interface awfe_in_if;
    import awfe_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- src/awfe_out_if.sv -----
`default_nettype none
interface awfe_out_if;
    import awfe_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- src/accel_window_feature_extractor_core.sv -----
// Sliding window of the last DEPTH three-axis accelerometer samples with a
// one-request-at-a-time controller. A feature request walks the single-port
// sample memory one sample per cycle, then runs a 24-step bit-serial divider
// for the mean delta; a full-window dump alternates a memory read and an
// output load for each result, each load waiting until the output register
// is free. A new request is taken only once the previous one has loaded its
// last result into the output register; that result may still wait to be
// taken.
`default_nettype none
module accel_window_feature_extractor_core #(
    parameter int DEPTH = awfe_pkg::AWFE_DEPTH_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    awfe_in_if.sink   in_ch,
    awfe_out_if.source out_ch
);
    import awfe_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    awfe_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    awfe_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cmd    (cmd),
        .stat   (stat)
    );
endmodule
`default_nettype wire

// ----- src/awfe_div.sv -----
`default_nettype none
module awfe_div #(
    parameter int DIVISOR_W = 6
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [awfe_pkg::ENERGY_W-1:0]  dividend,
    input  wire logic [DIVISOR_W-1:0]           divisor,
    output logic                                done,
    output logic [awfe_pkg::ENERGY_W-1:0]       quotient
);
    import awfe_pkg::*;

    localparam int STEP_W = $clog2(ENERGY_W);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [ENERGY_W-1:0]  quo_reg, quo_next;
    logic [DIVISOR_W-1:0] div_reg, div_next;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;

    // one restoring step per cycle, quotient bits shift in from the right
    always_comb
    begin
        trial     = {rem_reg, quo_reg[ENERGY_W-1]};
        diff      = trial - {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[ENERGY_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[ENERGY_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(ENERGY_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// ----- src/awfe_ctrl.sv -----
`default_nettype none
module awfe_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire awfe_pkg::stat_t stat,
    output awfe_pkg::cmd_t      cmd
);
    import awfe_pkg::*;

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (stat.in_fire)
                    state_next = S_DECODE;
            S_DECODE:
            begin
                unique case (stat.op)
                    OP_PUSH: state_next = S_EMIT_PUSH;
                    OP_FEAT: state_next = stat.empty ? S_EMIT_ERR : S_FEAT_WALK;
                    OP_DUMP: state_next = stat.full ? S_DUMP_RD : S_EMIT_ERR;
                    OP_RAW:  state_next = stat.age_bad ? S_EMIT_ERR : S_EMIT_RAW;
                    default: state_next = S_EMIT_ERR;
                endcase
            end
            S_FEAT_WALK:
                if (stat.walk_done && !stat.rd_pend)
                    state_next = S_DIV_START;
            S_DIV_START:
                state_next = S_DIV_WAIT;
            S_DIV_WAIT:
                if (stat.div_done)
                    state_next = S_EMIT_FEAT;
            S_DUMP_RD:
                state_next = S_DUMP_EMIT;
            S_DUMP_EMIT:
                if (stat.out_free)
                    state_next = stat.walk_done ? S_IDLE : S_DUMP_RD;
            S_EMIT_PUSH, S_EMIT_ERR, S_EMIT_RAW, S_EMIT_FEAT:
                if (stat.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd          = '0;
        cmd.out_kind = RES_ERR;
        unique case (state_reg)
            S_IDLE:
                cmd.take = 1'b1;
            S_DECODE:
            begin
                cmd.push      = (stat.op == OP_PUSH);
                cmd.raw_issue = (stat.op == OP_RAW) && !stat.age_bad;
            end
            S_FEAT_WALK:
                cmd.walk_issue = !stat.walk_done;
            S_DIV_START:
                cmd.div_start = 1'b1;
            S_DIV_WAIT:
                cmd.div_start = 1'b0;
            S_DUMP_RD:
                cmd.walk_issue = 1'b1;
            S_DUMP_EMIT:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_kind = RES_DUMP;
            end
            S_EMIT_PUSH:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_kind = RES_PUSH;
            end
            S_EMIT_ERR:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_kind = RES_ERR;
            end
            S_EMIT_RAW:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_kind = RES_RAW;
            end
            S_EMIT_FEAT:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_kind = RES_FEAT;
            end
            default:
                cmd.take = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

// ----- src/awfe_dp.sv -----
`default_nettype none
`include "accel_window_feature_extractor_core_assert.svh"
module awfe_dp #(
    parameter int DEPTH = awfe_pkg::AWFE_DEPTH_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    awfe_in_if.sink              in_ch,
    awfe_out_if.source           out_ch,
    input  wire awfe_pkg::cmd_t  cmd,
    output awfe_pkg::stat_t      stat
);
    import awfe_pkg::*;

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 3 * SAMPLE_W;

    typedef logic signed [SAMPLE_W-1:0] smp_t;

    // sample store, no reset
    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    in_item_t          item_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] oldest_reg, oldest_next;
    logic [CNT_W-1:0]  walk_reg, walk_next;
    logic              rd_valid_reg, rd_first_reg;
    logic              out_valid_reg;
    out_item_t         out_reg, out_next;

    smp_t              mn_reg [3];
    smp_t              mx_reg [3];
    smp_t              prev_reg [3];
    smp_t              base_reg [3];
    logic [ENERGY_W-1:0] energy_reg, energy_next;

    logic              in_fire, out_fire, full;
    logic [CNT_W-1:0]  age;
    logic [CNT_W:0]    slot_sum;
    logic [SLOT_W-1:0] slot;
    logic              rd_en;
    smp_t              rd_smp [3];
    smp_t              base_sel [3];
    logic [SPAN_W-1:0] span [3];
    logic [SPAN_W-1:0] best;
    logic [ENERGY_W-1:0] step_sum;
    logic              div_done;
    logic [ENERGY_W-1:0] quotient;
    logic [CNT_W-1:0]  divisor_full;

    assign in_fire  = in_ch.valid && cmd.take;
    assign out_fire = out_valid_reg && out_ch.ready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign in_ch.ready = cmd.take;

    // status back to the controller
    always_comb
    begin
        stat.in_fire   = in_fire;
        stat.op        = item_reg.opcode;
        stat.empty     = (count_reg == '0);
        stat.full      = full;
        stat.age_bad   = ({1'b0, item_reg.age_index} >= FILL_W'(count_reg));
        stat.walk_done = (walk_reg == count_reg);
        stat.rd_pend   = rd_valid_reg;
        stat.out_free  = !out_valid_reg || out_ch.ready;
        stat.div_done  = div_done;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_reg <= in_ch.payload;
    end

    // age to slot, sum stays below twice the depth
    always_comb
    begin
        if (cmd.push)
            age = count_reg;
        else if (cmd.raw_issue)
            age = CNT_W'(item_reg.age_index);
        else
            age = walk_reg;
        slot_sum = {1'b0, CNT_W'(oldest_reg)} + {1'b0, age};
        if (slot_sum >= (CNT_W + 1)'(DEPTH))
            slot_sum = slot_sum - (CNT_W + 1)'(DEPTH);
        slot = slot_sum[SLOT_W-1:0];
    end

    // push bookkeeping, full window overwrites the oldest slot
    always_comb
    begin
        count_next  = count_reg;
        oldest_next = oldest_reg;
        if (cmd.push)
        begin
            if (!full)
                count_next = count_reg + 1'b1;
            else if (oldest_reg == SLOT_W'(DEPTH - 1))
                oldest_next = '0;
            else
                oldest_next = oldest_reg + 1'b1;
        end
    end

    assign rd_en     = cmd.walk_issue || cmd.raw_issue;
    assign walk_next = in_fire ? '0 : (cmd.walk_issue ? walk_reg + 1'b1 : walk_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.push)
            mem[full ? oldest_reg : slot] <= {item_reg.accel_x, item_reg.accel_y,
                                              item_reg.accel_z};
        if (rd_en)
            rd_data_reg <= mem[cmd.push ? oldest_reg : slot];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            oldest_reg    <= '0;
            walk_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            rd_first_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            oldest_reg    <= oldest_next;
            walk_reg      <= walk_next;
            rd_valid_reg  <= cmd.walk_issue;
            rd_first_reg  <= cmd.walk_issue && (walk_reg == '0);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    assign rd_smp[0] = rd_data_reg[3*SAMPLE_W-1:2*SAMPLE_W];
    assign rd_smp[1] = rd_data_reg[2*SAMPLE_W-1:SAMPLE_W];
    assign rd_smp[2] = rd_data_reg[SAMPLE_W-1:0];

    // feature accumulation over the walk
    always_comb
    begin
        logic signed [SAMPLE_W:0] d;
        step_sum = '0;
        for (int a = 0; a < 3; a++)
        begin
            d = {rd_smp[a][SAMPLE_W-1], rd_smp[a]} - {prev_reg[a][SAMPLE_W-1], prev_reg[a]};
            step_sum = step_sum + ENERGY_W'(d[SAMPLE_W] ? -d : d);
        end
        energy_next = energy_reg;
        if (rd_valid_reg)
            energy_next = rd_first_reg ? '0 : energy_reg + step_sum;
    end

    always_ff @(posedge clk)
    begin
        energy_reg <= energy_next;
        for (int a = 0; a < 3; a++)
        begin
            if (rd_valid_reg)
            begin
                prev_reg[a] <= rd_smp[a];
                if (rd_first_reg || rd_smp[a] < mn_reg[a])
                    mn_reg[a] <= rd_smp[a];
                if (rd_first_reg || rd_smp[a] > mx_reg[a])
                    mx_reg[a] <= rd_smp[a];
            end
            if (cmd.out_load && cmd.out_kind == RES_DUMP && walk_reg == CNT_W'(1))
                base_reg[a] <= rd_smp[a];
        end
    end

    // mean of the deltas
    assign divisor_full = count_reg - 1'b1;

    awfe_div #(
        .DIVISOR_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (energy_reg),
        .divisor  (divisor_full),
        .done     (div_done),
        .quotient (quotient)
    );

    // result assembly
    always_comb
    begin
        logic signed [SAMPLE_W:0] dd;
        logic signed [8:0]        q;
        smp_t                     nv [3];
        best = '0;
        for (int a = 0; a < 3; a++)
        begin
            span[a] = SPAN_W'(mx_reg[a] - mn_reg[a]);
            if (span[a] > best)
                best = span[a];
            base_sel[a] = (walk_reg == CNT_W'(1)) ? rd_smp[a] : base_reg[a];
            dd = {rd_smp[a][SAMPLE_W-1], rd_smp[a]} - {base_sel[a][SAMPLE_W-1], base_sel[a]};
            q  = dd[SAMPLE_W:8];
            if (dd[SAMPLE_W] && dd[7:0] != '0)
                q = q + 9'sd1;
            if (q > NORM_MAX)
                q = NORM_MAX;
            else if (q < NORM_MIN)
                q = NORM_MIN;
            nv[a] = SAMPLE_W'(q);
        end

        out_next            = '0;
        out_next.fill_count = FILL_W'(count_reg);
        out_next.last       = 1'b1;
        out_next.status     = STATUS_OK;
        unique case (cmd.out_kind)
            RES_PUSH:
                out_next.status = STATUS_OK;
            RES_ERR:
                out_next.status = STATUS_ERR;
            RES_RAW:
            begin
                out_next.sample_x = rd_smp[0];
                out_next.sample_y = rd_smp[1];
                out_next.sample_z = rd_smp[2];
            end
            RES_DUMP:
            begin
                out_next.sample_x = nv[0];
                out_next.sample_y = nv[1];
                out_next.sample_z = nv[2];
                out_next.last     = (walk_reg == count_reg);
            end
            RES_FEAT:
            begin
                out_next.span_x       = span[0];
                out_next.span_y       = span[1];
                out_next.span_z       = span[2];
                out_next.largest_span = best;
                out_next.delta_energy = energy_reg;
                out_next.mean_delta   = (count_reg == CNT_W'(1)) ? '0 : quotient[MEAN_W-1:0];
            end
            default:
                out_next.status = STATUS_ERR;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_reg <= out_next;
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_reg;

    `AWFE_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `AWFE_ASSERT_IMPLY(a_oldest_until_full, clk, rst_n, !full, oldest_reg == '0)
    `AWFE_ASSERT_NEXT(a_push_grows, clk, rst_n, cmd.push && !full,
        count_reg == $past(count_reg) + 1'b1)
    `AWFE_ASSERT_IMPLY(a_load_free, clk, rst_n, cmd.out_load, !out_valid_reg || out_ch.ready)
endmodule
`default_nettype wire
